// ----- rtl/core/txra_pkg.sv -----
`default_nettype none

package txra_pkg;

    // Sizes of the statistics store.
    localparam int RATE_COUNT  = 10;
    localparam int COUNT_WIDTH = 32;
    localparam int RATE_IDX_W  = $clog2(RATE_COUNT);

    // Field widths.
    localparam int RATE_W  = 4;
    localparam int PROBE_W = 4;
    localparam int PCT_W   = 7;
    localparam int CFG_W   = 4;

    // Register reset values.
    localparam logic [RATE_W-1:0]  RESET_START_RATE     = RATE_W'(4);
    localparam logic [RATE_W-1:0]  RESET_MAX_RATE       = RATE_W'(9);
    localparam logic [PROBE_W-1:0] RESET_PROBE_INTERVAL = PROBE_W'(10);
    localparam logic [PROBE_W-1:0] PROBE_COUNT_MAX      = PROBE_W'(15);

    // Percentage arithmetic.
    localparam int PCT_SCALE  = 100;
    localparam int OLD_WEIGHT = 7;
    localparam int NEW_WEIGHT = 3;
    localparam int SUM_W      = 10;
    // x / 10 equals (x * 205) >> 11 for every x below 1024.
    localparam int SMOOTH_RECIP = 205;
    localparam int SMOOTH_SHIFT = 11;
    localparam int PROD_W       = SUM_W + 8;

    // Serial divider sizes: the dividend is successes * 100.
    localparam int NUM_W = COUNT_WIDTH + PCT_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {
        CFG_START_RATE     = 2'd0,
        CFG_MAX_RATE       = 2'd1,
        CFG_PROBE_INTERVAL = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quot;
    } t_div_res;

endpackage

`default_nettype wire

// ----- rtl/core/tx_rate_adaptation.sv -----
// Request words: the result is registered, then loaded into the output register.
// Completion words: the result is computed by the bit-serial divider that shifts
// one of the 39 dividend bits per cycle.
// One word is in work at a time; the output register frees the input side early.
// Synchronous active-low reset restores config and state registers and clears all statistics.
`default_nettype none

module tx_rate_adaptation import txra_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_command,
    input  wire logic [RATE_W-1:0]  i_rate_index,
    input  wire logic               i_success,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [RATE_W-1:0]       o_rate_out,
    output logic                    o_is_probe,
    output logic [PCT_W-1:0]        o_success_percent,
    output logic [PCT_W-1:0]        o_smoothed_percent,
    output logic                    o_bad_index
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOAD   = 6'b000010,
        S_START  = 6'b000100,
        S_DIV    = 6'b001000,
        S_SUM    = 6'b010000,
        S_SMOOTH = 6'b100000
    } t_state_core;

    // Output handoff is tracked apart from the core states.
    t_state_core r_state, n_state;
    logic        r_pending, n_pending;

    logic [RATE_W-1:0]  r_max_rate;
    logic [PROBE_W-1:0] r_probe_interval;
    logic [RATE_W-1:0]  r_cur_rate, n_cur_rate;
    logic [PROBE_W-1:0] r_probe_count, n_probe_count;

    logic [COUNT_WIDTH-1:0] r_attempt [RATE_COUNT];
    logic [COUNT_WIDTH-1:0] r_success [RATE_COUNT];
    logic [PCT_W-1:0]       r_smooth  [RATE_COUNT];

    logic [RATE_W-1:0]      r_idx;
    logic                   r_ok;
    logic [COUNT_WIDTH-1:0] r_att, n_att;
    logic [COUNT_WIDTH-1:0] r_suc, n_suc;
    logic [PCT_W-1:0]       r_pct;
    logic [SUM_W-1:0]       r_sum, n_sum;

    logic [RATE_W-1:0] r_res_rate;
    logic              r_res_probe;
    logic [PCT_W-1:0]  r_res_pct;
    logic [PCT_W-1:0]  r_res_smooth;
    logic              r_res_bad;

    logic              r_out_valid;
    logic [RATE_W-1:0] r_out_rate;
    logic              r_out_probe;
    logic [PCT_W-1:0]  r_out_pct;
    logic [PCT_W-1:0]  r_out_smooth;
    logic              r_out_bad;

    logic                  in_accept;
    logic                  out_load;
    logic                  idx_bad;
    logic                  take_probe;
    logic [PROBE_W-1:0]    probe_inc;
    logic [RATE_IDX_W-1:0] slot;
    logic [PROD_W-1:0]     smooth_prod;
    logic [PCT_W-1:0]      smooth_val;
    t_div_res              div_res;

    assign o_in_stall = (r_state != S_IDLE) || r_pending;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_load   = r_pending && (!r_out_valid || !i_out_stall);
    assign slot       = r_idx[RATE_IDX_W-1:0];
    assign idx_bad    = {28'd0, i_rate_index} >= 32'(RATE_COUNT);

    assign probe_inc  = (r_probe_count == PROBE_COUNT_MAX) ? r_probe_count
                                                           : r_probe_count + PROBE_W'(1);
    assign take_probe = (probe_inc >= r_probe_interval) && (r_cur_rate < r_max_rate);

    assign smooth_prod = PROD_W'(r_sum) * PROD_W'(SMOOTH_RECIP);
    assign smooth_val  = smooth_prod[SMOOTH_SHIFT +: PCT_W];

    txra_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_state == S_START),
        .i_successes (r_suc),
        .i_attempts  (r_att),
        .o_res       (div_res)
    );

    always_comb begin
        n_state       = r_state;
        n_pending     = r_pending;
        n_cur_rate    = r_cur_rate;
        n_probe_count = r_probe_count;
        n_att         = (r_attempt[slot] != '1) ? r_attempt[slot] + COUNT_WIDTH'(1)
                                                : r_attempt[slot];
        n_suc         = (r_ok && (r_success[slot] != '1)) ? r_success[slot] + COUNT_WIDTH'(1)
                                                          : r_success[slot];
        n_sum         = SUM_W'(r_smooth[slot]) * SUM_W'(OLD_WEIGHT)
                      + SUM_W'(r_pct) * SUM_W'(NEW_WEIGHT);
        if (out_load) begin
            n_pending = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (!i_command) begin
                        n_probe_count = take_probe ? '0 : probe_inc;
                        n_pending     = 1'b1;
                    end else if (idx_bad) begin
                        n_pending = 1'b1;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                if (!r_ok && (r_cur_rate != '0)) begin
                    n_cur_rate = r_cur_rate - RATE_W'(1);
                end
                n_state = S_START;
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_res.done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_state = S_SMOOTH;
            end
            S_SMOOTH: begin
                n_pending = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_pending        <= 1'b0;
            r_max_rate       <= RESET_MAX_RATE;
            r_probe_interval <= RESET_PROBE_INTERVAL;
            r_cur_rate       <= RESET_START_RATE;
            r_probe_count    <= '0;
            r_out_valid      <= 1'b0;
            for (int i = 0; i < RATE_COUNT; i++) begin
                r_attempt[i] <= '0;
                r_success[i] <= '0;
                r_smooth[i]  <= '0;
            end
        end else begin
            r_state       <= n_state;
            r_pending     <= n_pending;
            r_cur_rate    <= n_cur_rate;
            r_probe_count <= n_probe_count;
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    // The start rate is reloaded by reset, which also restores
                    // its default, so a write leaves no trace.
                    CFG_START_RATE:     ;
                    CFG_MAX_RATE:       r_max_rate <= i_cfg_data;
                    CFG_PROBE_INTERVAL: r_probe_interval <= i_cfg_data;
                    default:            ;
                endcase
            end
            if (r_state == S_LOAD) begin
                r_attempt[slot] <= n_att;
                r_success[slot] <= n_suc;
            end
            if (r_state == S_SMOOTH) begin
                r_smooth[slot] <= smooth_val;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_idx        <= i_rate_index;
            r_ok         <= i_success;
            r_res_rate   <= (!i_command && take_probe) ? r_cur_rate + RATE_W'(1) : r_cur_rate;
            r_res_probe  <= !i_command && take_probe;
            r_res_pct    <= '0;
            r_res_smooth <= '0;
            r_res_bad    <= i_command && idx_bad;
        end
        if (r_state == S_LOAD) begin
            r_att <= n_att;
            r_suc <= n_suc;
        end
        if ((r_state == S_DIV) && div_res.done) begin
            r_pct <= div_res.quot;
        end
        if (r_state == S_SUM) begin
            r_sum <= n_sum;
        end
        if (r_state == S_SMOOTH) begin
            r_res_rate   <= r_cur_rate;
            r_res_pct    <= r_pct;
            r_res_smooth <= smooth_val;
        end
        if (out_load) begin
            r_out_rate   <= r_res_rate;
            r_out_probe  <= r_res_probe;
            r_out_pct    <= r_res_pct;
            r_out_smooth <= r_res_smooth;
            r_out_bad    <= r_res_bad;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_rate_out         = r_out_rate;
    assign o_is_probe         = r_out_probe;
    assign o_success_percent  = r_out_pct;
    assign o_smoothed_percent = r_out_smooth;
    assign o_bad_index        = r_out_bad;

endmodule

`default_nettype wire

// ----- rtl/core/txra_div.sv -----
`default_nettype none

module txra_div import txra_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [COUNT_WIDTH-1:0] i_successes,
    input  wire logic [COUNT_WIDTH-1:0] i_attempts,
    output t_div_res                    o_res
);

    logic [NUM_W-1:0]       r_num;
    logic [COUNT_WIDTH-1:0] r_den;
    logic [COUNT_WIDTH-1:0] r_rem;
    logic [PCT_W-1:0]       r_quot;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_done;

    logic [COUNT_WIDTH:0] trial;
    logic [COUNT_WIDTH:0] diff;
    logic                 fits;

    // One dividend bit enters the partial remainder each cycle, MSB first.
    assign trial = {r_rem, r_num[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= NUM_W'(i_successes) * NUM_W'(PCT_SCALE);
                r_den  <= i_attempts;
                r_rem  <= '0;
                r_quot <= '0;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_cnt != '0) begin
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
                r_rem  <= fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
                // The quotient never exceeds 100, so only its low bits are kept.
                r_quot <= {r_quot[PCT_W-2:0], fits};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;

endmodule

`default_nettype wire

// ----- tb/txra_checker.sv -----
`timescale 1ns / 1ps

package txra_tb_pkg;

    typedef enum logic {
        CMD_REQUEST  = 1'b0,
        CMD_COMPLETE = 1'b1
    } t_command;

endpackage

module txra_checker import txra_pkg::*; import txra_tb_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic               i_command,
    input  wire logic [RATE_W-1:0]  i_rate_index,
    input  wire logic               i_success,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic [RATE_W-1:0]  i_rate_out,
    input  wire logic               i_is_probe,
    input  wire logic [PCT_W-1:0]   i_success_percent,
    input  wire logic [PCT_W-1:0]   i_smoothed_percent,
    input  wire logic               i_bad_index,
    input  wire logic               i_end_check,
    output int                      o_pending,
    output int                      o_errors
);

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic              probe;
        logic [PCT_W-1:0]  pct;
        logic [PCT_W-1:0]  smooth;
        logic              bad;
    } t_rate_word;

    t_rate_word expected_words[$];
    t_rate_word got_word;
    t_rate_word want_word;

    logic [RATE_W-1:0]      start_rate_q;
    logic [RATE_W-1:0]      max_rate_q;
    logic [PROBE_W-1:0]     probe_interval_q;
    logic [RATE_W-1:0]      cur_rate;
    logic [PROBE_W-1:0]     probe_cnt;
    logic [COUNT_WIDTH-1:0] attempts [RATE_COUNT];
    logic [COUNT_WIDTH-1:0] successes [RATE_COUNT];
    logic [PCT_W-1:0]       smoothed [RATE_COUNT];

    int errors = 0;
    int pending = 0;
    bit end_done = 1'b0;

    assign o_errors  = errors;
    assign o_pending = pending;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Advances the rate state by one word and returns the result it must produce.
    function automatic t_rate_word next_rate_word(input logic cmd,
                                                  input logic [RATE_W-1:0] idx,
                                                  input logic ok);
        t_rate_word             r;
        logic [COUNT_WIDTH-1:0] ceiling;
        longint unsigned        pct;
        int unsigned            blend;
        r = '0;
        ceiling = '1;
        if (cmd == CMD_REQUEST) begin
            if (probe_cnt < PROBE_COUNT_MAX) begin
                probe_cnt = probe_cnt + 1'b1;
            end
            if (probe_cnt >= probe_interval_q && cur_rate < max_rate_q) begin
                probe_cnt = '0;
                r.rate = cur_rate + 1'b1;
                r.probe = 1'b1;
            end else begin
                r.rate = cur_rate;
            end
        end else if (int'(idx) >= RATE_COUNT) begin
            // An out-of-range rate leaves every counter alone.
            r.rate = cur_rate;
            r.bad = 1'b1;
        end else begin
            if (attempts[idx] != ceiling) begin
                attempts[idx] = attempts[idx] + 1'b1;
            end
            if (ok && successes[idx] != ceiling) begin
                successes[idx] = successes[idx] + 1'b1;
            end
            pct = (64'(successes[idx]) * 64'(PCT_SCALE)) / 64'(attempts[idx]);
            blend = (32'(smoothed[idx]) * OLD_WEIGHT + 32'(pct) * NEW_WEIGHT) / 10;
            smoothed[idx] = PCT_W'(blend);
            if (!ok && cur_rate != '0) begin
                cur_rate = cur_rate - 1'b1;
            end
            r.rate = cur_rate;
            r.pct = PCT_W'(pct);
            r.smooth = PCT_W'(blend);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_rate_q = RESET_START_RATE;
            max_rate_q = RESET_MAX_RATE;
            probe_interval_q = RESET_PROBE_INTERVAL;
            cur_rate = RESET_START_RATE;
            probe_cnt = '0;
            for (int k = 0; k < RATE_COUNT; k++) begin
                attempts[k] = '0;
                successes[k] = '0;
                smoothed[k] = '0;
            end
            expected_words.delete();
            pending = 0;
        end else begin
            // The start rate is stored but never takes effect; reset restores the default.
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_START_RATE:     start_rate_q = i_cfg_data;
                    CFG_MAX_RATE:       max_rate_q = i_cfg_data;
                    CFG_PROBE_INTERVAL: probe_interval_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_words.push_back(next_rate_word(i_command, i_rate_index, i_success));
            end
            if (i_out_valid && !i_out_stall) begin
                got_word = '{i_rate_out, i_is_probe, i_success_percent,
                             i_smoothed_percent, i_bad_index};
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing expected: %p", got_word));
                end else begin
                    want_word = expected_words.pop_front();
                    if (got_word.rate !== want_word.rate)
                        report_mismatch($sformatf("rate_out got %0d want %0d",
                                                  got_word.rate, want_word.rate));
                    if (got_word.probe !== want_word.probe)
                        report_mismatch($sformatf("is_probe got %0d want %0d",
                                                  got_word.probe, want_word.probe));
                    if (got_word.pct !== want_word.pct)
                        report_mismatch($sformatf("success_percent got %0d want %0d",
                                                  got_word.pct, want_word.pct));
                    if (got_word.smooth !== want_word.smooth)
                        report_mismatch($sformatf("smoothed_percent got %0d want %0d",
                                                  got_word.smooth, want_word.smooth));
                    if (got_word.bad !== want_word.bad)
                        report_mismatch($sformatf("bad_index got %0d want %0d",
                                                  got_word.bad, want_word.bad));
                end
            end
            pending = expected_words.size();
            if (i_end_check && !end_done) begin
                end_done = 1'b1;
                if (expected_words.size() != 0)
                    report_mismatch($sformatf("%0d result words never arrived",
                                              expected_words.size()));
            end
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import txra_pkg::*;
    import txra_tb_pkg::*;

    localparam int WORDS_PER_PHASE = 50;
    localparam int RANDOM_PHASES   = 9;
    localparam int LONG_HOLD       = 100;
    localparam int DRAIN_CYCLES    = 60;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    t_cfg_index        i_cfg_index = CFG_START_RATE;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    t_command          i_command = CMD_REQUEST;
    logic [RATE_W-1:0] i_rate_index = '0;
    logic              i_success = 1'b0;
    logic              i_out_stall = 1'b0;
    logic              end_check = 1'b0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic [RATE_W-1:0] o_rate_out;
    logic              o_is_probe;
    logic [PCT_W-1:0]  o_success_percent;
    logic [PCT_W-1:0]  o_smoothed_percent;
    logic              o_bad_index;

    int errors;
    int pending;
    int idle_pct = 0;
    bit hold_req = 1'b0;

    always #1 i_clk = ~i_clk;

    tx_rate_adaptation u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_rate_index       (i_rate_index),
        .i_success          (i_success),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_rate_out         (o_rate_out),
        .o_is_probe         (o_is_probe),
        .o_success_percent  (o_success_percent),
        .o_smoothed_percent (o_smoothed_percent),
        .o_bad_index        (o_bad_index)
    );

    txra_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_rate_index       (i_rate_index),
        .i_success          (i_success),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_rate_out         (o_rate_out),
        .i_is_probe         (o_is_probe),
        .i_success_percent  (o_success_percent),
        .i_smoothed_percent (o_smoothed_percent),
        .i_bad_index        (o_bad_index),
        .i_end_check        (end_check),
        .o_pending          (pending),
        .o_errors           (errors)
    );

    // The first edge is skipped so that a word accepted just now is already counted.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic set_rates(input logic [CFG_W-1:0] start, input logic [CFG_W-1:0] maxr,
                             input logic [CFG_W-1:0] interval);
        wait_drained();
        write_reg(CFG_START_RATE, start);
        write_reg(CFG_MAX_RATE, maxr);
        write_reg(CFG_PROBE_INTERVAL, interval);
        write_reg(CFG_UNUSED, CFG_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_word(input t_command cmd, input logic [RATE_W-1:0] idx,
                             input logic ok);
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_rate_index <= idx;
        i_success <= ok;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int count, input int req_pct);
        t_command          cmd;
        logic [RATE_W-1:0] idx;
        logic              ok;
        for (int n = 0; n < count; n++) begin
            cmd = ($urandom_range(0, 99) < req_pct) ? CMD_REQUEST : CMD_COMPLETE;
            // Mostly valid rates, with an occasional out-of-range one.
            idx = ($urandom_range(0, 9) == 0) ? RATE_W'($urandom_range(RATE_COUNT, 15))
                                              : RATE_W'($urandom_range(0, RATE_COUNT - 1));
            ok = ($urandom_range(0, 99) < 85);
            send_word(cmd, idx, ok);
        end
    endtask

    // Receiver side: short random stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        int burst_left;
        hold_left = 0;
        burst_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                burst_left = $urandom_range(0, 3);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 20;

        // Reset settings: start 4, max 9, interval 10.
        send_word(CMD_REQUEST, 4'hF, 1'b1);
        send_word(CMD_COMPLETE, 4'd0, 1'b1);
        send_word(CMD_COMPLETE, 4'd9, 1'b1);
        send_word(CMD_COMPLETE, RATE_W'(RATE_COUNT), 1'b1);
        send_word(CMD_COMPLETE, 4'hF, 1'b0);
        send_word(CMD_COMPLETE, 4'd9, 1'b0);

        // A new start rate must not move the current rate.
        set_rates(4'hF, 4'hF, 4'd1);
        repeat (3) send_word(CMD_REQUEST, 4'd0, 1'b0);

        // Current rate above the maximum with a zero interval.
        set_rates(4'd0, 4'd0, 4'd0);
        repeat (2) send_word(CMD_REQUEST, 4'd5, 1'b1);
        set_rates(4'd0, 4'hF, 4'd0);
        send_word(CMD_REQUEST, 4'd0, 1'b0);

        // Current rate equal to the maximum.
        set_rates(4'd7, 4'd3, 4'd2);
        repeat (2) send_word(CMD_REQUEST, 4'd0, 1'b0);
        send_word(CMD_COMPLETE, 4'd0, 1'b0);
        send_word(CMD_COMPLETE, 4'd0, 1'b1);
        send_word(CMD_COMPLETE, 4'd0, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                // No probe is possible here, so the probe counter saturates.
                set_rates(CFG_W'($urandom), 4'd0, 4'hF);
            end else begin
                set_rates(CFG_W'($urandom), CFG_W'($urandom_range(0, 15)),
                          CFG_W'($urandom_range(1, 15)));
            end
            idle_pct = (p == RANDOM_PHASES - 1) ? 0 : 15 * $urandom_range(0, 2);
            if (p == 4) begin
                hold_req = 1'b1;
                send_random(16, 100);
            end
            send_random(WORDS_PER_PHASE, (p == 0) ? 90 : 50);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/txra_pkg.sv
rtl/core/txra_div.sv
rtl/core/tx_rate_adaptation.sv
tb/txra_checker.sv
tb/tb_top.sv
